>>> src/midi_parser_14bit_cc_top_macros.svh
// ============================================================================
// midi_parser_14bit_cc_top_macros.svh
// Assertion macros shared by the checker of the MIDI 14-bit CC parser.
// ============================================================================
`ifndef MIDI_PARSER_14BIT_CC_TOP_MACROS_SVH
`define MIDI_PARSER_14BIT_CC_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define MP14_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MP14_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked during reset.
`define MP14_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mp14cc_pkg.sv
// ============================================================================
// mp14cc_pkg
// Event codes and bus widths of the MIDI 14-bit CC parser.
// ============================================================================
`default_nettype none

package mp14cc_pkg;

    localparam logic [1:0] KIND_NOTE_ON  = 2'd0;
    localparam logic [1:0] KIND_NOTE_OFF = 2'd1;
    localparam logic [1:0] KIND_CC7      = 2'd2;
    localparam logic [1:0] KIND_CC14     = 2'd3;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_W       = 32;

endpackage

`default_nettype wire

>>> src/midi_parser_14bit_cc_top.sv
// ============================================================================
// midi_parser_14bit_cc_top
// MIDI byte parser with running status and paired 14-bit control changes.
// ============================================================================
// The input stream carries one MIDI byte per beat on i_s_tdata. Real-time
// bytes are dropped, status bytes set the running status, and each completed
// note or control message may give one event beat on the output stream.
// The event kind travels on o_m_tuser; o_m_tdata holds channel, number,
// value7, value14 and value10. The user must write the pair mask through
// i_cfg_we and i_cfg_wdata only while the block is idle, which the block
// itself does not enforce. One byte is accepted per cycle while o_s_tready
// is high. An event is registered from the byte that completes its
// message. The per-controller store is read when the first data byte of a
// message is taken and written when the message completes, so its single
// read port sets the one-byte-per-cycle figure with no added bubbles.
// After reset a clearing pass zeroes every entry of the store; o_s_tready is
// low during that pass, while configuration writes are taken as usual.
// The output has a result register and a skid stage, so a further event is
// held while another event waits; o_s_tready drops once both hold an event.
// ============================================================================
`default_nettype none

module midi_parser_14bit_cc_top (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Configuration: pair_cc_mask.
    input  wire logic                               i_cfg_we,
    input  wire logic [mp14cc_pkg::CFG_W-1:0]       i_cfg_wdata,
    // Input stream. tdata: [7:0] midi_byte.
    input  wire logic                               i_s_tvalid,
    output logic                                    o_s_tready,
    input  wire logic [mp14cc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // Output stream.
    output logic                                    o_m_tvalid,
    input  wire logic                               i_m_tready,
    // tdata: [3:0] channel, [10:4] number, [17:11] value7, [31:18] value14,
    //        [41:32] value10, [47:42] zero.
    output logic [mp14cc_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // tuser: [1:0] event_kind.
    output logic [mp14cc_pkg::OUT_TUSER_W-1:0]      o_m_tuser
);

    localparam int STORE_DEPTH = 512;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);

    typedef struct packed {
        logic       seen;
        logic [6:0] msb;
        logic       lvalid;
        logic [9:0] lval;
    } t_store;

    localparam int STORE_W = $bits(t_store);

    function automatic logic [1:0] msg_length(input logic [7:0] status);
        msg_length = (status[7:4] == 4'hC || status[7:4] == 4'hD) ? 2'd1 : 2'd2;
    endfunction

    logic [mp14cc_pkg::CFG_W-1:0]       r_mask;
    logic [7:0]                         r_rs;
    logic [1:0]                         r_need;
    logic [6:0]                         r_first;
    logic                               r_clr_busy;
    logic [STORE_AW-1:0]                r_clr_addr;
    logic                               r_out_valid;
    logic [mp14cc_pkg::OUT_TDATA_W-1:0] r_out_tdata;
    logic [mp14cc_pkg::OUT_TUSER_W-1:0] r_out_tuser;
    logic                               r_skd_valid;
    logic [mp14cc_pkg::OUT_TDATA_W-1:0] r_skd_tdata;
    logic [mp14cc_pkg::OUT_TUSER_W-1:0] r_skd_tuser;

    logic                               w_acc;
    logic [7:0]                         w_b;
    logic                               w_is_status;
    logic                               w_is_data;
    logic                               w_first_step;
    logic                               w_done_step;
    logic [3:0]                         w_ch;
    logic [STORE_W-1:0]                 w_rdata;
    t_store                             w_rd;
    logic [13:0]                        w_pos;
    logic [24:0]                        w_y;
    logic [10:0]                        w_q0;
    logic [14:0]                        w_r;
    logic [10:0]                        w_q;
    logic [9:0]                         w_v10;
    logic                               w_msb_hit;
    logic                               w_lsb_hit;

    logic                               n_push;
    logic [1:0]                         n_kind;
    logic [6:0]                         n_num;
    logic [6:0]                         n_v7;
    logic [13:0]                        n_v14;
    logic [9:0]                         n_v10;
    logic                               n_st_we;
    t_store                             n_st_wdata;
    logic [mp14cc_pkg::OUT_TDATA_W-1:0] n_tdata;

    logic                               w_ram_we;
    logic [STORE_AW-1:0]                w_ram_waddr;
    logic [STORE_W-1:0]                 w_ram_wdata;

    assign o_s_tready   = !r_clr_busy && !r_skd_valid;
    assign w_acc        = i_s_tvalid && o_s_tready;
    assign w_b          = i_s_tdata;
    assign w_is_status  = w_b[7] && (w_b[7:3] != 5'b11111);
    assign w_is_data    = !w_b[7];
    assign w_first_step = w_is_data && (r_rs != 8'd0) && (r_need == 2'd2);
    assign w_done_step  = w_is_data && (r_rs != 8'd0) && (r_need != 2'd2);
    assign w_ch         = r_rs[3:0];
    assign w_rd         = t_store'(w_rdata);

    // Rescale: floor((2046*pos + 16383) / 32766) = floor((1023*pos + 8191) / 16383).
    assign w_pos = {w_rd.msb, w_b[6:0]};
    assign w_y   = {1'b0, w_pos, 10'd0} - {11'd0, w_pos} + 25'd8191;
    assign w_q0  = w_y[24:14];
    assign w_r   = {1'b0, w_y[13:0]} + {4'd0, w_q0};
    assign w_q   = w_q0 + {10'd0, (w_r >= 15'd16383)};
    assign w_v10 = (w_q > 11'd1023) ? 10'd1023 : w_q[9:0];

    assign w_msb_hit = (r_first[6:5] == 2'b00) && r_mask[r_first[4:0]];
    assign w_lsb_hit = (r_first[6:5] == 2'b01) && r_mask[r_first[4:0]];

    always_comb begin
        n_push     = 1'b0;
        n_kind     = mp14cc_pkg::KIND_CC7;
        n_num      = r_first;
        n_v7       = w_b[6:0];
        n_v14      = 14'd0;
        n_v10      = 10'd0;
        n_st_we    = 1'b0;
        n_st_wdata = w_rd;
        if (w_done_step) begin
            case (r_rs[7:4])
                4'h8, 4'h9: begin
                    n_push = 1'b1;
                    n_kind = (r_rs[7:4] == 4'h9 && w_b[6:0] != 7'd0)
                           ? mp14cc_pkg::KIND_NOTE_ON : mp14cc_pkg::KIND_NOTE_OFF;
                end
                4'hB: begin
                    if (w_msb_hit) begin
                        n_st_we         = 1'b1;
                        n_st_wdata.seen = 1'b1;
                        n_st_wdata.msb  = w_b[6:0];
                    end else if (w_lsb_hit) begin
                        if (w_rd.seen && !(w_rd.lvalid && w_rd.lval == w_v10)) begin
                            n_st_we           = 1'b1;
                            n_st_wdata.lvalid = 1'b1;
                            n_st_wdata.lval   = w_v10;
                            n_push            = 1'b1;
                            n_kind            = mp14cc_pkg::KIND_CC14;
                            n_num             = {2'b00, r_first[4:0]};
                            n_v14             = w_pos;
                            n_v10             = w_v10;
                        end
                    end else begin
                        n_push = 1'b1;
                    end
                end
                default: begin
                    n_push = 1'b0;
                end
            endcase
        end
        n_push  = n_push && w_acc;
        n_st_we = n_st_we && w_acc;
    end

    assign n_tdata = {6'd0, n_v10, n_v14, n_v7, n_num, w_ch};

    assign w_ram_we    = r_clr_busy || n_st_we;
    assign w_ram_waddr = r_clr_busy ? r_clr_addr : {w_ch, r_first[4:0]};
    assign w_ram_wdata = r_clr_busy ? '0 : STORE_W'(n_st_wdata);

    mp14cc_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_acc && w_first_step),
        .i_raddr ({w_ch, w_b[4:0]}),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask     <= 32'h8008_B891;
            r_rs       <= 8'd0;
            r_need     <= 2'd0;
            r_first    <= 7'd0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (w_acc) begin
                if (w_is_status) begin
                    r_rs    <= w_b;
                    r_need  <= msg_length(w_b);
                    r_first <= 7'd0;
                end else if (w_first_step) begin
                    r_first <= w_b[6:0];
                    r_need  <= 2'd1;
                end else if (w_done_step) begin
                    r_need  <= msg_length(r_rs);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= n_push;
            end
        end else if (n_push) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skd_valid) begin
                r_out_tdata <= r_skd_tdata;
                r_out_tuser <= r_skd_tuser;
            end else if (n_push) begin
                r_out_tdata <= n_tdata;
                r_out_tuser <= n_kind;
            end
        end else if (n_push) begin
            r_skd_tdata <= n_tdata;
            r_skd_tuser <= n_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_tdata;
    assign o_m_tuser  = r_out_tuser;

endmodule

`default_nettype wire

>>> src/mp14cc_ram.sv
// ============================================================================
// mp14cc_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ============================================================================
`default_nettype none

module mp14cc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/mp14cc_checker.sv
// ============================================================================
// mp14cc_checker
// Port-level assertions for the MIDI 14-bit CC parser, bound to the top.
// ============================================================================
`default_nettype none

`include "midi_parser_14bit_cc_top_macros.svh"

module mp14cc_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_cfg_we,
    input wire logic [mp14cc_pkg::CFG_W-1:0]       i_cfg_wdata,
    input wire logic                               i_s_tvalid,
    input wire logic                               o_s_tready,
    input wire logic [mp14cc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input wire logic                               o_m_tvalid,
    input wire logic                               i_m_tready,
    input wire logic [mp14cc_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input wire logic [mp14cc_pkg::OUT_TUSER_W-1:0] o_m_tuser
);

    `MP14_ASSERT_NXT(a_stall_valid, o_m_tvalid && !i_m_tready, o_m_tvalid, "beat dropped")
    `MP14_ASSERT_NXT(a_stall_data, o_m_tvalid && !i_m_tready, $stable(o_m_tdata) && $stable(o_m_tuser), "stalled beat changed")
    `MP14_ASSERT_NOW(a_wide_zero, o_m_tvalid && (o_m_tuser != mp14cc_pkg::KIND_CC14), o_m_tdata[47:18] == 30'd0, "wide fields set on a narrow event")
    `MP14_ASSERT_NOW(a_cc14_num, o_m_tvalid && (o_m_tuser == mp14cc_pkg::KIND_CC14), o_m_tdata[10:9] == 2'b00, "14-bit event with MSB number above 31")
    `MP14_ASSERT_RST(a_clear_pass, !i_rst_n, !o_s_tready, "input ready during store clear")

endmodule

bind midi_parser_14bit_cc_top mp14cc_checker u_mp14cc_checker (.*);

`default_nettype wire

>>> tb/sv/midi_parser_14bit_cc_top_tb.sv
// ============================================================================
// midi_parser_14bit_cc_top_tb
// Self-checking testbench of the MIDI parser with paired 14-bit control changes.
// ============================================================================
// A driver feeds raw MIDI bytes from a queue, and a monitor predicts every
// event from the accepted bytes. Each output beat is then compared field by
// field with the oldest predicted event. The stimulus starts with a short
// directed sequence: running status, note-on with zero velocity, real-time
// bytes inside messages, orphan data bytes, LSBs with and without an MSB and
// unchanged 14-bit values. It then sends random message streams under several
// pair masks, all ones and all zeros among them. Both stream sides stall in
// random bursts, except in the last, quiet stream.
// ============================================================================
`default_nettype none

module midi_parser_14bit_cc_top_tb;

    localparam logic [3:0]  ST_NOTE_OFF = 4'h8;
    localparam logic [3:0]  ST_NOTE_ON  = 4'h9;
    localparam logic [3:0]  ST_POLY     = 4'hA;
    localparam logic [3:0]  ST_CC       = 4'hB;
    localparam logic [3:0]  ST_PROGRAM  = 4'hC;
    localparam logic [3:0]  ST_PRESSURE = 4'hD;
    localparam logic [3:0]  ST_BEND     = 4'hE;
    localparam logic [3:0]  ST_SYSTEM   = 4'hF;
    localparam logic [7:0]  RT_FIRST    = 8'hF8;
    localparam logic [7:0]  SYS_LAST    = 8'hF7;
    localparam int          PAIR_OFFSET = 32;
    localparam logic [31:0] MASK_RESET  = 32'h8008B891;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  channel;
        logic [6:0]  number;
        logic [6:0]  value7;
        logic [13:0] value14;
        logic [9:0]  value10;
    } t_midi_event;

    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_cfg_we    = 1'b0;
    logic [mp14cc_pkg::CFG_W-1:0]       i_cfg_wdata = '0;
    logic                               i_s_tvalid  = 1'b0;
    logic                               o_s_tready;
    logic [mp14cc_pkg::IN_TDATA_W-1:0]  i_s_tdata   = '0;
    logic                               o_m_tvalid;
    logic                               i_m_tready  = 1'b0;
    logic [mp14cc_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic [mp14cc_pkg::OUT_TUSER_W-1:0] o_m_tuser;

    midi_parser_14bit_cc_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [7:0]  pending_bytes[$];
    t_midi_event expected_events[$];
    int          mismatches = 0;
    bit          byte_taken = 1'b0;
    bit          quiet      = 1'b0;
    logic [7:0]  gen_status = '0;

    logic [31:0] pair_mask = MASK_RESET;
    logic [7:0]  running_status = '0;
    logic [1:0]  bytes_needed = '0;
    logic [6:0]  first_data = '0;
    logic [6:0]  msb_store[512];
    bit          msb_seen[512];
    bit          scaled_valid[512];
    logic [9:0]  scaled_last[512];

    initial begin
        for (int i = 0; i < 512; i++) begin
            msb_store[i]    = '0;
            msb_seen[i]     = 1'b0;
            scaled_valid[i] = 1'b0;
            scaled_last[i]  = '0;
        end
    end

    function automatic logic [1:0] message_length(input logic [7:0] status);
        return (status[7:4] == ST_PROGRAM || status[7:4] == ST_PRESSURE) ? 2'd1 : 2'd2;
    endfunction

    function automatic logic [7:0] status_byte(input logic [3:0] kind, input logic [3:0] ch);
        return {kind, ch};
    endfunction

    // Advances the parser state by one byte; returns 1 when an event results.
    function automatic bit predict_event(input logic [7:0] b, output t_midi_event ev);
        logic [3:0]  ch;
        logic [6:0]  num;
        logic [8:0]  idx;
        int unsigned pos;
        int unsigned scaled;
        ev = '0;
        if (b >= RT_FIRST)
            return 1'b0;
        if (b[7]) begin
            running_status = b;
            bytes_needed   = message_length(b);
            first_data     = '0;
            return 1'b0;
        end
        if (running_status == 8'd0)
            return 1'b0;
        if (bytes_needed == 2'd2) begin
            first_data   = b[6:0];
            bytes_needed = 2'd1;
            return 1'b0;
        end
        bytes_needed = message_length(running_status);
        ch  = running_status[3:0];
        num = first_data;
        ev.channel = ch;
        ev.number  = num;
        ev.value7  = b[6:0];
        if (running_status[7:4] == ST_NOTE_ON || running_status[7:4] == ST_NOTE_OFF) begin
            ev.kind = (running_status[7:4] == ST_NOTE_ON && b != 8'd0)
                    ? mp14cc_pkg::KIND_NOTE_ON : mp14cc_pkg::KIND_NOTE_OFF;
            return 1'b1;
        end
        if (running_status[7:4] != ST_CC)
            return 1'b0;
        if (num < PAIR_OFFSET && pair_mask[num[4:0]]) begin
            idx = {ch, num[4:0]};
            msb_store[idx] = b[6:0];
            msb_seen[idx]  = 1'b1;
            return 1'b0;
        end
        if (num >= PAIR_OFFSET && num < 2 * PAIR_OFFSET && pair_mask[num[4:0]]) begin
            idx = {ch, num[4:0]};
            if (!msb_seen[idx])
                return 1'b0;
            pos    = {msb_store[idx], b[6:0]};
            scaled = (2 * pos * 1023 + 16383) / 32766;
            if (scaled > 1023)
                scaled = 1023;
            if (scaled_valid[idx] && scaled_last[idx] == scaled[9:0])
                return 1'b0;
            scaled_valid[idx] = 1'b1;
            scaled_last[idx]  = scaled[9:0];
            ev.kind    = mp14cc_pkg::KIND_CC14;
            ev.number  = {2'b00, num[4:0]};
            ev.value14 = pos[13:0];
            ev.value10 = scaled[9:0];
            return 1'b1;
        end
        ev.kind = mp14cc_pkg::KIND_CC7;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic compare_field(input string name, input int unsigned got,
                                 input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin : monitor
        t_midi_event want;
        t_midi_event predicted;
        byte_taken = 1'b0;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_events.size() == 0) begin
                    report_mismatch($sformatf("event beat with none expected, tdata %h",
                                              o_m_tdata));
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event_kind", o_m_tuser, want.kind);
                    compare_field("channel", o_m_tdata[3:0], want.channel);
                    compare_field("number", o_m_tdata[10:4], want.number);
                    compare_field("value7", o_m_tdata[17:11], want.value7);
                    compare_field("value14", o_m_tdata[31:18], want.value14);
                    compare_field("value10", o_m_tdata[41:32], want.value10);
                    compare_field("padding", o_m_tdata[47:42], 0);
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                byte_taken = 1'b1;
                if (predict_event(i_s_tdata, predicted))
                    expected_events.push_back(predicted);
            end
        end
    end

    int send_gap  = 0;
    int send_calm = 0;

    always @(negedge i_clk) begin : driver
        logic       nv;
        logic [7:0] nd;
        nv = i_s_tvalid;
        nd = i_s_tdata;
        if (send_calm > 0)
            send_calm--;
        else if ($urandom_range(0, 199) == 0)
            send_calm = $urandom_range(30, 120);
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!i_s_tvalid || byte_taken) begin
            nv = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end else if (!quiet && send_calm == 0 && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 6);
            end else if (pending_bytes.size() > 0) begin
                nv = 1'b1;
                nd = pending_bytes.pop_front();
            end
        end
        i_s_tvalid <= nv;
        i_s_tdata  <= nd;
    end

    int stall_left = 0;
    int stall_calm = 0;

    always @(negedge i_clk) begin : receiver
        logic nr;
        nr = 1'b1;
        if (stall_calm > 0)
            stall_calm--;
        else if ($urandom_range(0, 199) == 0)
            stall_calm = $urandom_range(30, 120);
        if (stall_left > 0) begin
            stall_left--;
            nr = 1'b0;
        end else if (!quiet && stall_calm == 0 && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            nr = 1'b0;
        end
        i_m_tready <= nr;
    end

    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(0, 24) == 0)
            pending_bytes.push_back(8'($urandom_range(RT_FIRST, 8'hFF)));
        pending_bytes.push_back(b);
        if (b[7] && b <= SYS_LAST)
            gen_status = b;
    endtask

    task automatic push_status(input logic [3:0] kind, input logic [3:0] ch);
        if (status_byte(kind, ch) != gen_status || $urandom_range(0, 3) == 0)
            push_byte(status_byte(kind, ch));
    endtask

    function automatic logic [7:0] random_data();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    task automatic gen_message();
        logic [3:0] ch;
        logic [6:0] n;
        logic [7:0] v;
        int         sel;
        ch  = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 2));
        n   = 7'($urandom_range(0, PAIR_OFFSET - 1));
        sel = $urandom_range(0, 99);
        if (sel < 30) begin
            push_status(($urandom_range(0, 9) < 7) ? ST_NOTE_ON : ST_NOTE_OFF, ch);
            push_byte(random_data());
            push_byte(($urandom_range(0, 5) == 0) ? 8'h00 : random_data());
        end else if (sel < 75) begin
            case ($urandom_range(0, 3))
                0: begin
                    push_status(ST_CC, ch);
                    push_byte({1'b0, n});
                    push_byte(random_data());
                end
                1: begin
                    push_status(ST_CC, ch);
                    push_byte(8'({1'b0, n} + PAIR_OFFSET));
                    push_byte(random_data());
                end
                2: begin
                    push_status(ST_CC, ch);
                    push_byte({1'b0, n});
                    push_byte(random_data());
                    v = random_data();
                    push_status(ST_CC, ch);
                    push_byte(8'({1'b0, n} + PAIR_OFFSET));
                    push_byte(v);
                    if ($urandom_range(0, 2) == 0) begin
                        push_byte(8'({1'b0, n} + PAIR_OFFSET));
                        push_byte(v);
                    end
                end
                default: begin
                    push_status(ST_CC, ch);
                    push_byte(random_data());
                    push_byte(random_data());
                end
            endcase
        end else if (sel < 88) begin
            case ($urandom_range(0, 4))
                0: begin
                    push_status(ST_PROGRAM, ch);
                    push_byte(random_data());
                end
                1: begin
                    push_status(ST_PRESSURE, ch);
                    push_byte(random_data());
                end
                2: begin
                    push_status(ST_POLY, ch);
                    push_byte(random_data());
                    push_byte(random_data());
                end
                3: begin
                    push_status(ST_BEND, ch);
                    push_byte(random_data());
                    push_byte(random_data());
                end
                default: begin
                    push_byte(8'($urandom_range(status_byte(ST_SYSTEM, 4'h0), SYS_LAST)));
                    repeat ($urandom_range(0, 3)) push_byte(random_data());
                end
            endcase
        end else if (sel < 94) begin
            push_byte(status_byte(4'($urandom_range(ST_NOTE_OFF, ST_BEND)), ch));
            repeat ($urandom_range(0, 1)) push_byte(random_data());
        end else begin
            push_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic gen_stream(input int count);
        int target;
        target = pending_bytes.size() + count;
        while (pending_bytes.size() < target)
            gen_message();
    endtask

    task automatic wait_for_idle();
        do
            @(negedge i_clk);
        while (pending_bytes.size() != 0 || i_s_tvalid || expected_events.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_mask(input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        pair_mask    = value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(RT_FIRST);
        pending_bytes.push_back(status_byte(ST_NOTE_ON, 4'h0));
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(status_byte(ST_NOTE_OFF, 4'hF));
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(status_byte(ST_PROGRAM, 4'h5));
        pending_bytes.push_back(8'h10);
        pending_bytes.push_back(8'h11);
        pending_bytes.push_back(status_byte(ST_SYSTEM, 4'h0));
        pending_bytes.push_back(8'h01);
        pending_bytes.push_back(8'h02);
        pending_bytes.push_back(status_byte(ST_CC, 4'h0));
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'(PAIR_OFFSET));
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'(PAIR_OFFSET));
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(status_byte(ST_CC, 4'h1));
        pending_bytes.push_back(8'(PAIR_OFFSET + 7));
        pending_bytes.push_back(8'h05);
        pending_bytes.push_back(status_byte(ST_CC, 4'hF));
        pending_bytes.push_back(8'h7F);
        pending_bytes.push_back(8'h7F);
        gen_status = status_byte(ST_CC, 4'hF);
        gen_stream(350);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait_for_idle();
        write_mask(32'hFFFF_FFFF);
        gen_stream(300);
        wait_for_idle();
        write_mask(32'h0000_0000);
        gen_stream(300);
        wait_for_idle();
        write_mask($urandom);
        gen_stream(300);
        wait_for_idle();
        write_mask($urandom);
        quiet = 1'b1;
        gen_stream(300);
        wait_for_idle();

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
